// ===== hw/rtl/pvva_pkg.sv =====
`default_nettype none

package pvva_pkg;

    // Store size and derived widths.
    localparam int MAX_VOICES = 16;
    localparam int POS_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CNT_W      = $clog2(MAX_VOICES + 1);

    // Fixed widths of the port fields.
    localparam int KIND_W     = 3;
    localparam int PITCH_W    = 7;
    localparam int MASK_W     = 16;
    localparam int STATUS_W   = 2;
    localparam int OUT_POS_W  = 4;
    localparam int OUT_CNT_W  = 5;
    localparam int LIMIT_W    = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;

    // Event codes.
    localparam logic [KIND_W-1:0] KIND_NOTE_ON       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ALL_NOTES_OFF = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ALL_SOUND_OFF = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RENDER_TICK   = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;

    // Contents of one cell of the voice chain.
    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic               released;
        logic               finished;
    } voice_t;

    // Operation broadcast to every cell in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD_MASK,
        CELL_APPEND,
        CELL_RELEASE_MATCH,
        CELL_RELEASE_ALL,
        CELL_REMOVE_RELEASED,
        CELL_REMOVE_FINISHED
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [PITCH_W-1:0] pitch;
    } cell_ctl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEAL,
        ST_APPEND,
        ST_RELEASE,
        ST_RELEASE_ALL,
        ST_MARK,
        ST_COMPACT,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pvva_cell.sv =====
`default_nettype none

module pvva_cell (
    input  wire logic                clk,
    input  wire pvva_pkg::cell_ctl_t ctl,
    input  wire logic                occupied,
    input  wire logic                append_here,
    input  wire logic                mask_bit,
    input  wire pvva_pkg::voice_t    right_voice,
    input  wire logic                found_in,
    output pvva_pkg::voice_t         voice,
    output logic                     found_out,
    output logic                     first_hit
);

    pvva_pkg::voice_t voice_reg;
    pvva_pkg::voice_t voice_next;
    logic             hit;

    // Match condition of this cell for the searching operations.
    always_comb
    begin
        case (ctl.op)
            pvva_pkg::CELL_RELEASE_MATCH:
                hit = occupied && !voice_reg.released && (voice_reg.pitch == ctl.pitch);
            pvva_pkg::CELL_REMOVE_RELEASED:
                hit = occupied && voice_reg.released;
            pvva_pkg::CELL_REMOVE_FINISHED:
                hit = occupied && voice_reg.finished;
            default:
                hit = 1'b0;
        endcase
    end

    // The search result ripples toward the end of the chain.
    assign found_out = found_in || hit;
    assign first_hit = hit && !found_in;

    // Next contents: a removal at or below this cell pulls in the right neighbor.
    always_comb
    begin
        voice_next = voice_reg;
        case (ctl.op)
            pvva_pkg::CELL_LOAD_MASK:
            begin
                voice_next.finished = mask_bit && occupied;
            end
            pvva_pkg::CELL_APPEND:
            begin
                if (append_here)
                begin
                    voice_next.pitch    = ctl.pitch;
                    voice_next.released = 1'b0;
                    voice_next.finished = 1'b0;
                end
            end
            pvva_pkg::CELL_RELEASE_MATCH:
            begin
                if (first_hit)
                begin
                    voice_next.released = 1'b1;
                end
            end
            pvva_pkg::CELL_RELEASE_ALL:
            begin
                if (occupied)
                begin
                    voice_next.released = 1'b1;
                end
            end
            pvva_pkg::CELL_REMOVE_RELEASED,
            pvva_pkg::CELL_REMOVE_FINISHED:
            begin
                if (found_out)
                begin
                    voice_next = right_voice;
                end
            end
            default:
            begin
                voice_next = voice_reg;
            end
        endcase
    end

    // Voice contents are payload and need no reset.
    always_ff @(posedge clk)
    begin
        voice_reg <= voice_next;
    end

    assign voice = voice_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/polyphonic_voice_allocator_unit.sv =====
// Sequence: note_on passes the steal and append states before the done strobe; note_off
// the release state; all_notes_off the release-all state; all_sound_off and other codes
// the finish state; render_tick the mark state and then the compact state, repeated while
// finished voices remain, since the cell chain removes one per cycle. A new event is accepted
// in the cycle of the done strobe. Results are shown for one cycle and the receiver cannot stall.
// Reset (rst_n low, asynchronous): empty voice list, polyphony limit 8, block idle.
`default_nettype none

module polyphonic_voice_allocator_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [pvva_pkg::KIND_W-1:0]        kind,
    input  wire logic [pvva_pkg::PITCH_W-1:0]       note_pitch,
    input  wire logic [pvva_pkg::MASK_W-1:0]        finished_mask,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pvva_pkg::LIMIT_W-1:0]       cfg_data,
    output logic                                    done,
    output logic [pvva_pkg::STATUS_W-1:0]           status,
    output logic [pvva_pkg::OUT_POS_W-1:0]          voice_position,
    output logic                                    stole_voice,
    output logic [pvva_pkg::OUT_POS_W-1:0]          stolen_position,
    output logic                                    stop_all,
    output logic [pvva_pkg::OUT_CNT_W-1:0]          voice_count,
    output logic                                    any_active
);

    localparam int NV = pvva_pkg::MAX_VOICES;

    pvva_pkg::state_t                  state_reg, state_next;
    logic [pvva_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [pvva_pkg::LIMIT_W-1:0]      limit_reg, limit_next;
    logic [pvva_pkg::PITCH_W-1:0]      pitch_reg, pitch_next;
    logic [pvva_pkg::MASK_W-1:0]       mask_reg, mask_next;
    logic                              done_reg, done_next;
    logic [pvva_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [pvva_pkg::OUT_POS_W-1:0]    vpos_reg, vpos_next;
    logic                              stole_reg, stole_next;
    logic [pvva_pkg::OUT_POS_W-1:0]    spos_reg, spos_next;
    logic                              stop_reg, stop_next;
    logic                              active_reg, active_next;

    pvva_pkg::cell_ctl_t               cell_ctl;
    pvva_pkg::voice_t                  chain_voice [NV+1];
    logic [NV:0]                       found_chain;
    logic [NV-1:0]                     first_hit;
    logic [NV-1:0]                     occupied;
    logic [NV-1:0]                     append_here;
    logic [NV-1:0]                     mask_ext;
    logic [pvva_pkg::POS_W-1:0]        hit_pos;
    logic                              found_any;
    logic                              steal_try;

    // Per-position occupancy and mask bits; positions beyond the mask never finish.
    genvar g;
    generate
        for (g = 0; g < NV; g++)
        begin : g_pos
            assign occupied[g]    = (pvva_pkg::CNT_W'(g) < count_reg);
            assign append_here[g] = (pvva_pkg::CNT_W'(g) == count_reg);
            if (g < pvva_pkg::MASK_W)
            begin : g_mask
                assign mask_ext[g] = mask_reg[g];
            end
            else
            begin : g_nomask
                assign mask_ext[g] = 1'b0;
            end
        end
    endgenerate

    // The chain of voice cells; the cell past the end feeds an empty voice.
    assign chain_voice[NV] = '0;
    assign found_chain[0]  = 1'b0;

    generate
        for (g = 0; g < NV; g++)
        begin : g_cell
            pvva_cell u_cell (
                .clk         (clk),
                .ctl         (cell_ctl),
                .occupied    (occupied[g]),
                .append_here (append_here[g]),
                .mask_bit    (mask_ext[g]),
                .right_voice (chain_voice[g+1]),
                .found_in    (found_chain[g]),
                .voice       (chain_voice[g]),
                .found_out   (found_chain[g+1]),
                .first_hit   (first_hit[g])
            );
        end
    endgenerate

    assign found_any = found_chain[NV];

    // Encode the one-hot first hit into a position.
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < NV; i++)
        begin
            if (first_hit[i])
            begin
                hit_pos = hit_pos | pvva_pkg::POS_W'(i);
            end
        end
    end

    assign steal_try = (count_reg >= limit_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pvva_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        pvva_pkg::KIND_NOTE_ON:       state_next = pvva_pkg::ST_STEAL;
                        pvva_pkg::KIND_NOTE_OFF:      state_next = pvva_pkg::ST_RELEASE;
                        pvva_pkg::KIND_ALL_NOTES_OFF: state_next = pvva_pkg::ST_RELEASE_ALL;
                        pvva_pkg::KIND_RENDER_TICK:   state_next = pvva_pkg::ST_MARK;
                        default:                      state_next = pvva_pkg::ST_FINISH;
                    endcase
                end
            end
            pvva_pkg::ST_STEAL:       state_next = pvva_pkg::ST_APPEND;
            pvva_pkg::ST_MARK:        state_next = pvva_pkg::ST_COMPACT;
            pvva_pkg::ST_COMPACT:
            begin
                if (!found_any)
                begin
                    state_next = pvva_pkg::ST_IDLE;
                end
            end
            pvva_pkg::ST_APPEND,
            pvva_pkg::ST_RELEASE,
            pvva_pkg::ST_RELEASE_ALL,
            pvva_pkg::ST_FINISH:      state_next = pvva_pkg::ST_IDLE;
            default:                  state_next = pvva_pkg::ST_IDLE;
        endcase
    end

    // Cell operation, counters and result fields for each state.
    always_comb
    begin
        cell_ctl.op    = pvva_pkg::CELL_HOLD;
        cell_ctl.pitch = pitch_reg;
        count_next     = count_reg;
        limit_next     = limit_reg;
        pitch_next     = pitch_reg;
        mask_next      = mask_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        vpos_next      = vpos_reg;
        stole_next     = stole_reg;
        spos_next      = spos_reg;
        stop_next      = stop_reg;
        active_next    = active_reg;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        case (state_reg)
            pvva_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    pitch_next  = note_pitch;
                    mask_next   = finished_mask;
                    status_next = pvva_pkg::STATUS_DONE;
                    vpos_next   = '0;
                    stole_next  = 1'b0;
                    spos_next   = '0;
                    stop_next   = (kind == pvva_pkg::KIND_ALL_SOUND_OFF);
                    active_next = 1'b0;
                end
            end
            pvva_pkg::ST_STEAL:
            begin
                if (steal_try)
                begin
                    cell_ctl.op = pvva_pkg::CELL_REMOVE_RELEASED;
                    if (found_any)
                    begin
                        count_next = count_reg - 1'b1;
                        stole_next = 1'b1;
                        spos_next  = pvva_pkg::OUT_POS_W'(hit_pos);
                    end
                end
            end
            pvva_pkg::ST_APPEND:
            begin
                done_next = 1'b1;
                if (count_reg >= pvva_pkg::CNT_W'(NV))
                begin
                    status_next = pvva_pkg::STATUS_FULL;
                end
                else
                begin
                    cell_ctl.op = pvva_pkg::CELL_APPEND;
                    vpos_next   = pvva_pkg::OUT_POS_W'(count_reg);
                    count_next  = count_reg + 1'b1;
                end
            end
            pvva_pkg::ST_RELEASE:
            begin
                cell_ctl.op = pvva_pkg::CELL_RELEASE_MATCH;
                done_next   = 1'b1;
                if (found_any)
                begin
                    vpos_next = pvva_pkg::OUT_POS_W'(hit_pos);
                end
                else
                begin
                    status_next = pvva_pkg::STATUS_NO_MATCH;
                end
            end
            pvva_pkg::ST_RELEASE_ALL:
            begin
                cell_ctl.op = pvva_pkg::CELL_RELEASE_ALL;
                done_next   = 1'b1;
            end
            pvva_pkg::ST_MARK:
            begin
                cell_ctl.op = pvva_pkg::CELL_LOAD_MASK;
                active_next = |(occupied & ~mask_ext);
            end
            pvva_pkg::ST_COMPACT:
            begin
                cell_ctl.op = pvva_pkg::CELL_REMOVE_FINISHED;
                if (found_any)
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            pvva_pkg::ST_FINISH:
            begin
                done_next = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pvva_pkg::ST_IDLE;
            count_reg  <= '0;
            limit_reg  <= pvva_pkg::LIMIT_RESET;
            done_reg   <= 1'b0;
            status_reg <= pvva_pkg::STATUS_DONE;
            vpos_reg   <= '0;
            stole_reg  <= 1'b0;
            spos_reg   <= '0;
            stop_reg   <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            limit_reg  <= limit_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            vpos_reg   <= vpos_next;
            stole_reg  <= stole_next;
            spos_reg   <= spos_next;
            stop_reg   <= stop_next;
            active_reg <= active_next;
        end
    end

    // Event operands are payload and need no reset.
    always_ff @(posedge clk)
    begin
        pitch_reg <= pitch_next;
        mask_reg  <= mask_next;
    end

    assign busy            = (state_reg != pvva_pkg::ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign done            = done_reg;
    assign status          = status_reg;
    assign voice_position  = vpos_reg;
    assign stole_voice     = stole_reg;
    assign stolen_position = spos_reg;
    assign stop_all        = stop_reg;
    assign voice_count     = pvva_pkg::OUT_CNT_W'(count_reg);
    assign any_active      = active_reg;

    // The voice count never exceeds the store.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pvva_pkg::CNT_W'(NV))
        else $error("voice count beyond store size");

    // A result is only presented once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == pvva_pkg::ST_IDLE))
        else $error("result strobe while sequencer busy");

    // An accepted event makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted event did not start the sequencer");

    // A dropped note is reported only when the store is full.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == pvva_pkg::STATUS_FULL)) |-> (count_reg == pvva_pkg::CNT_W'(NV)))
        else $error("note dropped while store had room");

endmodule

`default_nettype wire
